[sv/mrwt_pkg.sv]
// Shared types and constants for the Miller-Rabin witness test core.
package mrwt_pkg;

   localparam int NBITS_DEFAULT = 64;
   localparam int FIELD_W = 64;

   localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
   localparam logic [1:0] VERDICT_PRIME     = 2'd1;
   localparam logic [1:0] VERDICT_BAD       = 2'd2;

   // Operand selection for the shared multiplier.
   localparam logic [1:0] SEL_MUL = 2'd0;  // r * base
   localparam logic [1:0] SEL_SQB = 2'd1;  // base * base
   localparam logic [1:0] SEL_SQR = 2'd2;  // r * r, one of the final squarings

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE   = 4'd0,
      OP_LOAD   = 4'd1,  // capture n and x, start x mod n
      OP_RED    = 4'd2,  // one restoring step of x mod n
      OP_SPLIT  = 4'd3,  // shift t right once, count s
      OP_RINIT  = 4'd4,  // r = 1, base = x
      OP_MSTART = 4'd5,  // start the product picked by mul_sel
      OP_MSTEP  = 4'd6,  // one double-and-add step
      OP_MDONE  = 4'd7,  // write product back
      OP_ESHIFT = 4'd8   // e >>= 1
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] mul_sel;
   } cmd_type;

   typedef struct packed {
      logic n_lt2;       // n below two
      logic x_zero;      // reduced witness is zero
      logic red_done;    // reduction finished
      logic t_even;      // t still even
      logic e_zero;      // exponent exhausted
      logic e_lsb;       // exponent low bit
      logic mul_done;    // multiply finished
      logic r_one;       // r == 1
      logic r_nm1;       // r == n-1
      logic s_zero;      // squaring budget used up
   } stat_type;

endpackage

[sv/miller_rabin_witness_test_core.sv]
// Top level of the Miller-Rabin witness test core.
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_stall    req_candidate, req_witness
//  rsp      out        rsp_valid/rsp_stall    rsp_verdict
//
// One item at a time. The witness reduction runs as restoring division steps, the
// split of n-1 shifts once per trailing zero, and each modular multiply runs
// bit-serially in the shared double-and-add unit; a test takes at most 2*NBITS
// multiplies. Reset is synchronous and returns the controller to idle. A held
// result stalls intake until it is transferred; a new item is taken in the same
// cycle as the transfer.
module miller_rabin_witness_test_core
   import mrwt_pkg::*;
#(
   parameter int NBITS = NBITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FIELD_W-1:0] req_candidate,
   input  logic [FIELD_W-1:0] req_witness,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_verdict
);

   cmd_type  cmd;
   stat_type stat;

   mrwt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .rsp_verdict, .cmd, .stat
   );

   mrwt_datapath #(.NBITS(NBITS)) u_dp (
      .clock, .req_candidate, .req_witness, .cmd, .stat
   );

`ifndef SYNTHESIS
   // A result never carries an undefined verdict code.
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERDICT_COMPOSITE || rsp_verdict == VERDICT_PRIME
                     || rsp_verdict == VERDICT_BAD))
      else $error("bad verdict code");
   // No intake while a held result is stalled.
   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("intake during stalled result");
   // A result appears only after an item was taken.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work");
`endif

endmodule

[sv/mrwt_datapath.sv]
// Datapath of the witness test: reduction, split of n-1, bit-serial modular multiply.
module mrwt_datapath
   import mrwt_pkg::*;
#(
   parameter int NBITS = NBITS_DEFAULT
) (
   input  logic               clock,
   input  logic [FIELD_W-1:0] req_candidate,
   input  logic [FIELD_W-1:0] req_witness,
   input  cmd_type            cmd,
   output stat_type           stat
);

   localparam int CW = $clog2(NBITS + 1);

   logic [NBITS-1:0] n_ff, n_in;
   logic [NBITS-1:0] x_ff, x_in;      // reduced witness / base
   logic [NBITS-1:0] e_ff, e_in;      // exponent t, consumed by pow
   logic [NBITS-1:0] r_ff, r_in;
   logic [NBITS-1:0] acc_ff, acc_in;  // product accumulator / reduction remainder
   logic [NBITS-1:0] ma_ff, ma_in;    // multiplicand
   logic [NBITS-1:0] mb_ff, mb_in;    // multiplier, shifted left each step
   logic [NBITS-1:0] q_ff, q_in;      // dividend bits during reduction
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    s_ff, s_in;

   // Modular add helper, all operands below n.
   function automatic logic [NBITS-1:0] madd(input logic [NBITS-1:0] a,
                                             input logic [NBITS-1:0] b,
                                             input logic [NBITS-1:0] m);
      logic [NBITS-1:0] room;
      room = m - b;
      if (a >= room) return a - room;
      return a + b;
   endfunction

   logic [NBITS-1:0] dbl, addv, nm1;
   logic [NBITS:0]   rem2;

   assign nm1  = n_ff - NBITS'(1);
   assign dbl  = madd(acc_ff, acc_ff, n_ff);
   assign addv = madd(dbl, ma_ff, n_ff);
   assign rem2 = {acc_ff, q_ff[NBITS-1]};

   always_comb begin
      n_in = n_ff; x_in = x_ff; e_in = e_ff; r_in = r_ff; acc_in = acc_ff;
      ma_in = ma_ff; mb_in = mb_ff; q_in = q_ff; cnt_in = cnt_ff; s_in = s_ff;
      case (cmd.op)
         OP_LOAD: begin
            n_in   = req_candidate[NBITS-1:0];
            q_in   = req_witness[NBITS-1:0];
            acc_in = '0;
            cnt_in = CW'(NBITS);
            s_in   = '0;
         end
         OP_RED: begin
            // One restoring division step of x by n.
            if (rem2 >= {1'b0, n_ff}) acc_in = NBITS'(rem2 - {1'b0, n_ff});
            else acc_in = rem2[NBITS-1:0];
            q_in   = q_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            e_in   = nm1;
            if (cnt_ff == CW'(1)) x_in = (rem2 >= {1'b0, n_ff}) ?
               NBITS'(rem2 - {1'b0, n_ff}) : rem2[NBITS-1:0];
         end
         OP_SPLIT: begin
            e_in = e_ff >> 1;
            s_in = s_ff + CW'(1);
         end
         OP_RINIT: begin
            r_in = NBITS'(1);
         end
         OP_MSTART: begin
            acc_in = '0;
            cnt_in = CW'(NBITS);
            case (cmd.mul_sel)
               SEL_MUL: begin ma_in = r_ff; mb_in = x_ff; end
               SEL_SQB: begin ma_in = x_ff; mb_in = x_ff; end
               default: begin ma_in = r_ff; mb_in = r_ff; end
            endcase
         end
         OP_MSTEP: begin
            acc_in = mb_ff[NBITS-1] ? addv : dbl;
            mb_in  = mb_ff << 1;
            cnt_in = cnt_ff - CW'(1);
         end
         OP_MDONE: begin
            if (cmd.mul_sel == SEL_SQB) x_in = acc_ff;
            else r_in = acc_ff;
            if (cmd.mul_sel == SEL_SQR) s_in = s_ff - CW'(1);
         end
         OP_ESHIFT: begin
            e_in = e_ff >> 1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; x_ff <= x_in; e_ff <= e_in; r_ff <= r_in; acc_ff <= acc_in;
      ma_ff <= ma_in; mb_ff <= mb_in; q_ff <= q_in; cnt_ff <= cnt_in; s_ff <= s_in;
   end

   // Status back to the controller.
   assign stat.n_lt2    = (n_ff < NBITS'(2));
   assign stat.x_zero   = (x_ff == '0);
   assign stat.red_done = (cnt_ff == '0);
   assign stat.t_even   = ~e_ff[0];
   assign stat.e_zero   = (e_ff == '0);
   assign stat.e_lsb    = e_ff[0];
   assign stat.mul_done = (cnt_ff == '0);
   assign stat.r_one    = (r_ff == NBITS'(1));
   assign stat.r_nm1    = (r_ff == nm1);
   assign stat.s_zero   = (s_ff == '0);

endmodule

[sv/mrwt_ctrl.sv]
// Controller state machine sequencing the witness test.
module mrwt_ctrl
   import mrwt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_verdict,
   output cmd_type    cmd,
   input  stat_type   stat
);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_CHECK  = 12'b000000000010,
      S_RED    = 12'b000000000100,
      S_XCHK   = 12'b000000001000,
      S_SPLIT  = 12'b000000010000,
      S_POWCHK = 12'b000000100000,
      S_MSTART = 12'b000001000000,
      S_MSTEP  = 12'b000010000000,
      S_MDONE  = 12'b000100000000,
      S_SQCHK  = 12'b001000000000,
      S_SPARE  = 12'b010000000000,
      S_DONE   = 12'b100000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic [1:0] verdict_ff, verdict_in;
   logic       busy;

   assign busy      = (state_ff != S_IDLE) && !(state_ff == S_DONE && !rsp_stall);
   assign req_stall = busy;
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_verdict = verdict_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff; sel_in = sel_ff; verdict_in = verdict_ff;
      cmd.op = OP_NONE; cmd.mul_sel = sel_ff;
      case (state_ff)
         S_IDLE, S_DONE: begin
            if (state_ff == S_IDLE || !rsp_stall) begin
               state_in = S_IDLE;
               if (req_valid) begin
                  cmd.op   = OP_LOAD;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (stat.n_lt2) begin
               verdict_in = VERDICT_BAD; state_in = S_DONE;
            end else state_in = S_RED;
         end
         S_RED: begin
            cmd.op = OP_RED;
            if (stat.red_done) state_in = S_XCHK;
         end
         S_XCHK: begin
            if (stat.x_zero) begin
               verdict_in = VERDICT_BAD; state_in = S_DONE;
            end else state_in = S_SPLIT;
         end
         S_SPLIT: begin
            if (stat.t_even) cmd.op = OP_SPLIT;
            else begin
               cmd.op = OP_RINIT; state_in = S_POWCHK;
            end
         end
         S_POWCHK: begin
            if (stat.e_zero) begin
               if (stat.r_one) begin
                  verdict_in = VERDICT_PRIME; state_in = S_DONE;
               end else state_in = S_SQCHK;
            end else begin
               sel_in = stat.e_lsb ? SEL_MUL : SEL_SQB;
               state_in = S_MSTART;
            end
         end
         S_MSTART: begin
            cmd.op = OP_MSTART; state_in = S_MSTEP;
         end
         S_MSTEP: begin
            if (stat.mul_done) state_in = S_MDONE;
            else cmd.op = OP_MSTEP;
         end
         S_MDONE: begin
            cmd.op = OP_MDONE;
            if (sel_ff == SEL_MUL) begin
               sel_in = SEL_SQB; state_in = S_MSTART;
            end else if (sel_ff == SEL_SQB) begin
               cmd.op = OP_MDONE; state_in = S_SPARE;
            end else state_in = S_SQCHK;
         end
         S_SPARE: begin
            cmd.op = OP_ESHIFT; state_in = S_POWCHK;
         end
         S_SQCHK: begin
            if (stat.s_zero) begin
               verdict_in = VERDICT_COMPOSITE; state_in = S_DONE;
            end else if (stat.r_nm1) begin
               verdict_in = VERDICT_PRIME; state_in = S_DONE;
            end else begin
               sel_in = SEL_SQR; state_in = S_MSTART;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      sel_ff     <= sel_in;
      verdict_ff <= verdict_in;
   end

endmodule

[tb/miller_rabin_witness_test_core_test.sv]
// Self-checking testbench for the Miller-Rabin witness test core.
`timescale 1ns / 1ps

module miller_rabin_witness_test_core_test;
   import mrwt_pkg::*;

   localparam int NBITS = NBITS_DEFAULT;
   localparam int IDLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 100;
   localparam int QUIET_ITEMS = 20;

   typedef struct {
      logic [FIELD_W-1:0] candidate;
      logic [FIELD_W-1:0] witness;
      bit                 typed;
      logic [1:0]         verdict;
   } vector_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [FIELD_W-1:0] req_candidate;
   logic [FIELD_W-1:0] req_witness;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_verdict;

   logic [1:0]  verdicts_due[$];
   vector_type  vectors[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          quiet = 0;

   miller_rabin_witness_test_core #(.NBITS(NBITS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_candidate(req_candidate), .req_witness(req_witness),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_verdict(rsp_verdict)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Modular product at double width, so nothing overflows.
   function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return 64'(p % {64'd0, m});
   endfunction

   // Verdict of one witness test on the low NBITS bits of each operand.
   function automatic logic [1:0] witness_verdict(logic [63:0] cand, logic [63:0] wit);
      logic [63:0] mask, n, x, nm1, t, a, r, e;
      int s;
      mask = {64{1'b1}} >> (64 - NBITS);
      n = cand & mask;
      x = wit & mask;
      if (n < 2) return VERDICT_BAD;
      x = x % n;
      if (x == 0) return VERDICT_BAD;
      nm1 = n - 1;
      t = nm1;
      s = 0;
      while (t[0] == 1'b0) begin
         t = t >> 1;
         s++;
      end
      r = 1;
      e = t;
      a = x;
      while (e != 0) begin
         if (e[0]) r = mul_mod(r, a, n);
         a = mul_mod(a, a, n);
         e = e >> 1;
      end
      if (r == 1) return VERDICT_PRIME;
      for (int j = 0; j < s; j++) begin
         if (r == nm1) return VERDICT_PRIME;
         r = mul_mod(r, r, n);
      end
      return VERDICT_COMPOSITE;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic add_vector(logic [63:0] cand, logic [63:0] wit, bit typed,
                             logic [1:0] verdict);
      vector_type v;
      v.candidate = cand;
      v.witness = wit;
      v.typed = typed;
      v.verdict = verdict;
      vectors.push_back(v);
   endtask

   // Present one test and hold it until the core takes the transfer.
   task automatic send_test(vector_type v, bit gap_allowed);
      int gap;
      req_valid <= 1'b1;
      req_candidate <= v.candidate;
      req_witness <= v.witness;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      verdicts_due.push_back(v.typed ? v.verdict : witness_verdict(v.candidate, v.witness));
      if (gap_allowed && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random result-side stall bursts, none once the run goes quiet.
   initial begin
      int burst;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
      end
   end

   // Compare every result transfer with the oldest expected verdict.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            report_mismatch("result transfer with no test outstanding");
         end else begin
            if (rsp_verdict !== verdicts_due[0])
               report_mismatch($sformatf("verdict %0d, expected %0d",
                                         rsp_verdict, verdicts_due[0]));
            void'(verdicts_due.pop_front());
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [63:0] cand, wit;
      int kind;
      reset = 1'b1;
      req_valid = 1'b0;
      req_candidate = '0;
      req_witness = '0;

      // Directed table: bad inputs, small cases, extremes, known pseudoprimes.
      add_vector(64'd0, 64'd5, 1, VERDICT_BAD);
      add_vector(64'd1, 64'd1, 1, VERDICT_BAD);
      add_vector(64'd7, 64'd0, 1, VERDICT_BAD);
      add_vector(64'd7, 64'd14, 1, VERDICT_BAD);
      add_vector(64'd2, 64'd1, 1, VERDICT_PRIME);
      add_vector(64'd2, 64'd3, 1, VERDICT_PRIME);
      add_vector(64'd2, 64'd4, 1, VERDICT_BAD);
      add_vector(64'd3, 64'd2, 1, VERDICT_PRIME);
      add_vector(64'd4, 64'd3, 1, VERDICT_COMPOSITE);
      add_vector(64'd9, 64'd2, 0, 0);
      add_vector(64'd13, 64'd100, 0, 0);
      add_vector(64'd561, 64'd2, 0, 0);
      add_vector(64'd2047, 64'd2, 1, VERDICT_PRIME);
      add_vector(64'd1000, 64'd999, 0, 0);
      add_vector(64'hFFFF_FFFF_FFFF_FFC5, 64'd2, 1, VERDICT_PRIME);
      add_vector(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC4, 1, VERDICT_PRIME);
      add_vector(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, VERDICT_BAD);
      add_vector(64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 0, 0);
      add_vector(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
      add_vector(64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) send_test(vectors[i], 1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Halfway, hold off until every outstanding verdict has come back.
         if (i == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            while (verdicts_due.size() != 0) @(posedge clock);
         end
         if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1;
         kind = $urandom_range(0, 3);
         cand = {$urandom, $urandom};
         wit = {$urandom, $urandom};
         case (kind)
            0: cand[0] = 1'b1;
            1: begin
               cand = $urandom_range(0, 1000);
               wit = $urandom_range(0, 2000);
            end
            2: begin
               // Primes near the top of the range with random witnesses.
               cand = (i % 2) ? 64'hFFFF_FFFF_FFFF_FFC5 : 64'd2305843009213693951;
            end
            default: ;
         endcase
         send_test('{candidate: cand, witness: wit, typed: 0, verdict: 2'd0}, !quiet);
      end
      req_valid <= 1'b0;

      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
